@@ rtl/swd_pkg.sv @@
package swd_pkg;

  // Configuration register indexes.
  localparam int CfgCount = 2;
  localparam logic [0:0] CFG_IDLE_LOW   = 1'b0;
  localparam logic [0:0] CFG_LRESET_ONE = 1'b1;

  // Operation codes carried by an input item.
  localparam logic [1:0] OP_LINE_RESET = 2'd0;
  localparam logic [1:0] OP_WRITE      = 2'd1;
  localparam logic [1:0] OP_READ       = 2'd2;
  localparam logic [1:0] OP_NONE       = 2'd3;

  // Completion status codes.
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_WAIT   = 3'd1;
  localparam logic [2:0] ST_FAULT  = 3'd2;
  localparam logic [2:0] ST_PROTO  = 3'd3;
  localparam logic [2:0] ST_PARITY = 3'd4;

  // Reset values of the configuration registers and fixed field lengths.
  localparam logic [7:0] IDLE_LOW_RESET   = 8'd16;
  localparam logic [7:0] LRESET_ONE_RESET = 8'd50;
  localparam logic [7:0] HEADER_BITS      = 8'd8;
  localparam logic [7:0] ACK_BITS         = 8'd3;
  localparam logic [7:0] DATA_BITS        = 8'd32;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_LRESET = 4'd1,
    PH_IDLELO = 4'd2,
    PH_HEADER = 4'd3,
    PH_TURN1  = 4'd4,
    PH_ACK    = 4'd5,
    PH_TURN2  = 4'd6,
    PH_WDATA  = 4'd7,
    PH_WPAR   = 4'd8,
    PH_RDATA  = 4'd9,
    PH_RPAR   = 4'd10
  } phase_t;

  typedef struct packed {
    logic        start_cmd;
    logic [1:0]  opcode;
    logic        port_select;
    logic [1:0]  reg_address;
    logic [31:0] write_data;
    logic        line_in;
  } swd_in_t;

  typedef struct packed {
    logic        clock_pulse;
    logic        line_out;
    logic        line_drive;
    logic        busy_res;
    logic        done_res;
    logic [2:0]  status;
    logic [31:0] read_data;
  } swd_out_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  bit_counter;
    logic [31:0] data_shift;
    logic        parity_acc;
    logic [2:0]  ack_bits;
    logic [7:0]  header_bits;
    logic        is_read;
    logic [31:0] last_read_word;
  } swd_state_t;

  typedef struct packed {
    logic [7:0] idle_low_cycles;
    logic [7:0] line_reset_ones;
  } swd_cfg_t;

  // Acknowledge check: exactly one bit must be set, else a protocol error, also when fault and wait are both set.
  function automatic logic [2:0] judge_ack(input logic [2:0] ack);
    logic [2:0] res;
    begin
      if ({1'b0, ack[0]} + {1'b0, ack[1]} + {1'b0, ack[2]} != 2'd1) begin
        res = ST_PROTO;
      end else if (ack[2]) begin
        res = ST_FAULT;
      end else if (ack[1]) begin
        res = ST_WAIT;
      end else begin
        res = ST_OK;
      end
      return res;
    end
  endfunction

endpackage

@@ rtl/swd_step.sv @@
module swd_step (
  input  swd_pkg::swd_state_t cur,
  input  swd_pkg::swd_in_t    item,
  input  swd_pkg::swd_cfg_t   cfg,
  output swd_pkg::swd_state_t nxt,
  output swd_pkg::swd_out_t   res
);
  import swd_pkg::*;

  // One wire bit period: start decode, phase exits, then the bit itself.
  always_comb begin
    swd_state_t s;
    logic       clk_p;
    logic       lo;
    logic       drv;
    logic       busy;
    logic       done;
    logic [2:0] st;
    logic       rnw;
    logic       par;
    logic [7:0] bc_inc;

    s     = cur;
    clk_p = 1'b0;
    lo    = 1'b0;
    drv   = 1'b0;
    busy  = 1'b0;
    done  = 1'b0;
    st    = ST_OK;
    rnw   = (item.opcode == OP_READ);
    par   = item.port_select ^ rnw ^ item.reg_address[0] ^ item.reg_address[1];

    // Unused phase codes behave as idle.
    if (s.phase > PH_RPAR) begin
      s.phase = PH_IDLE;
    end

    // A start is honored only while idle and with a defined opcode.
    if (s.phase == PH_IDLE && item.start_cmd && item.opcode != OP_NONE) begin
      s.bit_counter = '0;
      s.parity_acc  = 1'b0;
      s.ack_bits    = '0;
      if (item.opcode == OP_LINE_RESET) begin
        s.phase = PH_LRESET;
      end else begin
        s.is_read     = rnw;
        s.header_bits = {1'b1, 1'b0, par, item.reg_address[1], item.reg_address[0],
                         rnw, item.port_select, 1'b1};
        s.data_shift  = item.write_data;
        s.phase       = PH_IDLELO;
      end
    end

    busy = (s.phase != PH_IDLE);

    // Counts already reached end the phase before any bit goes out.
    if (s.phase == PH_LRESET && s.bit_counter >= cfg.line_reset_ones) begin
      done    = 1'b1;
      s.phase = PH_IDLE;
    end
    if (s.phase == PH_IDLELO && s.bit_counter >= cfg.idle_low_cycles) begin
      s.phase       = PH_HEADER;
      s.bit_counter = '0;
    end

    bc_inc = s.bit_counter + 8'd1;

    case (s.phase)
      PH_LRESET: begin
        clk_p = 1'b1;
        lo    = 1'b1;
        drv   = 1'b1;
        s.bit_counter = bc_inc;
        if (bc_inc >= cfg.line_reset_ones) begin
          done    = 1'b1;
          s.phase = PH_IDLE;
        end
      end
      PH_IDLELO: begin
        clk_p = 1'b1;
        drv   = 1'b1;
        s.bit_counter = bc_inc;
        if (bc_inc >= cfg.idle_low_cycles) begin
          s.phase       = PH_HEADER;
          s.bit_counter = '0;
        end
      end
      PH_HEADER: begin
        clk_p = 1'b1;
        drv   = 1'b1;
        lo    = s.header_bits[s.bit_counter[2:0]];
        s.bit_counter = bc_inc;
        if (bc_inc >= HEADER_BITS) begin
          s.phase       = PH_TURN1;
          s.bit_counter = '0;
        end
      end
      PH_TURN1: begin
        clk_p         = 1'b1;
        s.phase       = PH_ACK;
        s.bit_counter = '0;
      end
      PH_ACK: begin
        clk_p = 1'b1;
        s.ack_bits = s.ack_bits | (3'(item.line_in) << s.bit_counter[1:0]);
        s.bit_counter = bc_inc;
        if (bc_inc >= ACK_BITS) begin
          s.bit_counter = '0;
          if (s.is_read) begin
            st = judge_ack(s.ack_bits);
            if (st != ST_OK) begin
              done    = 1'b1;
              s.phase = PH_IDLE;
            end else begin
              s.phase      = PH_RDATA;
              s.data_shift = '0;
              s.parity_acc = 1'b0;
            end
          end else begin
            s.phase = PH_TURN2;
          end
        end
      end
      PH_TURN2: begin
        clk_p = 1'b1;
        st    = judge_ack(s.ack_bits);
        if (st != ST_OK) begin
          done    = 1'b1;
          s.phase = PH_IDLE;
        end else begin
          s.phase       = PH_WDATA;
          s.bit_counter = '0;
          s.parity_acc  = 1'b0;
        end
      end
      PH_WDATA: begin
        clk_p = 1'b1;
        drv   = 1'b1;
        lo    = s.data_shift[0];
        s.parity_acc  = s.parity_acc ^ s.data_shift[0];
        s.data_shift  = {1'b0, s.data_shift[31:1]};
        s.bit_counter = bc_inc;
        if (bc_inc >= DATA_BITS) begin
          s.phase = PH_WPAR;
        end
      end
      PH_WPAR: begin
        clk_p   = 1'b1;
        drv     = 1'b1;
        lo      = s.parity_acc;
        done    = 1'b1;
        s.phase = PH_IDLE;
      end
      PH_RDATA: begin
        clk_p = 1'b1;
        s.data_shift  = {item.line_in, s.data_shift[31:1]};
        s.parity_acc  = s.parity_acc ^ item.line_in;
        s.bit_counter = bc_inc;
        if (bc_inc >= DATA_BITS) begin
          s.phase = PH_RPAR;
        end
      end
      PH_RPAR: begin
        clk_p = 1'b1;
        s.parity_acc = s.parity_acc ^ item.line_in;
        if (s.parity_acc) begin
          st = ST_PARITY;
        end else begin
          s.last_read_word = s.data_shift;
        end
        done    = 1'b1;
        s.phase = PH_IDLE;
      end
      default: begin
      end
    endcase

    nxt             = s;
    res.clock_pulse = clk_p;
    res.line_out    = lo;
    res.line_drive  = drv;
    res.busy_res    = busy;
    res.done_res    = done;
    res.status      = done ? st : ST_OK;
    res.read_data   = s.last_read_word;
  end

endmodule

@@ rtl/swd_host_transaction_engine.sv @@
// Channel | Ports                              | Accepted when
// input   | in_valid, in_ready, in_data        | in_valid && in_ready
// result  | out_valid, out_ready, out_data     | out_valid && out_ready
// config  | cfg_wr_en, cfg_index, cfg_data     | cfg_wr_en
//
// Each item is one wire bit period and yields exactly one result item.
// An item is held in the input register; the bit sequencer then updates
// its state and loads the result register in the same cycle, so a new
// item can be taken every cycle while the result is not stalled, and its
// result is offered from the result register once the sequencer takes it.
// Reset is synchronous and active low; it returns the sequencer to idle.
// A stalled result holds the sequencer; the input register then holds one
// more item, after which in_ready drops until the result is taken.
module swd_host_transaction_engine (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  swd_pkg::swd_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output swd_pkg::swd_out_t out_data,
  input  logic             cfg_wr_en,
  input  logic [0:0]       cfg_index,
  input  logic [7:0]       cfg_data
);
  import swd_pkg::*;

  swd_in_t    in_data_r;
  logic       in_vld_r;
  logic       in_vld_nxt;
  swd_out_t   out_data_r;
  logic       out_vld_r;
  logic       out_vld_nxt;
  swd_state_t state_r;
  swd_state_t state_nxt;
  swd_out_t   res;
  swd_cfg_t   cfg_r;
  logic       fire;
  logic       in_take;

  // The sequencer advances when an item waits and the result slot is free or being taken.
  assign fire     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || fire;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (fire) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (fire) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  swd_step u_step (
    .cur  (state_r),
    .item (in_data_r),
    .cfg  (cfg_r),
    .nxt  (state_nxt),
    .res  (res)
  );

  // Handshake flags, sequencer state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      state_r   <= '{phase: PH_IDLE, default: '0};
      cfg_r     <= '{idle_low_cycles: IDLE_LOW_RESET, line_reset_ones: LRESET_ONE_RESET};
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (fire) begin
        state_r <= state_nxt;
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_IDLE_LOW:   cfg_r.idle_low_cycles <= cfg_data;
          CFG_LRESET_ONE: cfg_r.line_reset_ones <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
    if (fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_data_r.done_res |-> out_data_r.busy_res)
    else $error("done without busy");

  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_data_r.done_res |-> out_data_r.status == ST_OK)
    else $error("status set outside done");

  a_released_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_data_r.line_drive |-> !out_data_r.line_out)
    else $error("line level while released");

  a_idle_no_clock: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_data_r.busy_res |-> !out_data_r.clock_pulse)
    else $error("clock pulse while idle");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(state_r))
    else $error("state moved without an item");
`endif

endmodule
